@@ src/assert_macros.svh @@
// Assertion helpers shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication also checked while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token kinds and helpers for the script token scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package sts_pkg;

    localparam int OFFSET_BITS_DEF     = 32;
    localparam int LINE_BITS_DEF       = 24;
    localparam int KEYWORD_MAX_LEN_DEF = 6;

    localparam int KIND_W = 6;
    localparam int ERR_W  = 2;
    localparam int OUT_W  = 32;
    localparam int LINE_W = 24;

    localparam logic [KIND_W-1:0] K_LPAREN = 6'd0;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd3;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd4;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd5;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd6;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd7;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd8;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd9;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd10;
    localparam logic [KIND_W-1:0] K_BANG   = 6'd11;
    localparam logic [KIND_W-1:0] K_EQUAL  = 6'd13;
    localparam logic [KIND_W-1:0] K_GREATER = 6'd15;
    localparam logic [KIND_W-1:0] K_LESS   = 6'd17;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd19;
    localparam logic [KIND_W-1:0] K_STRING = 6'd20;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd21;
    localparam logic [KIND_W-1:0] K_AND    = 6'd22;
    localparam logic [KIND_W-1:0] K_CLASS  = 6'd23;
    localparam logic [KIND_W-1:0] K_ELSE   = 6'd24;
    localparam logic [KIND_W-1:0] K_FALSE  = 6'd25;
    localparam logic [KIND_W-1:0] K_FOR    = 6'd26;
    localparam logic [KIND_W-1:0] K_FN     = 6'd27;
    localparam logic [KIND_W-1:0] K_IF     = 6'd28;
    localparam logic [KIND_W-1:0] K_NIL    = 6'd29;
    localparam logic [KIND_W-1:0] K_OR     = 6'd30;
    localparam logic [KIND_W-1:0] K_PRINT  = 6'd31;
    localparam logic [KIND_W-1:0] K_RETURN = 6'd32;
    localparam logic [KIND_W-1:0] K_SUPER  = 6'd33;
    localparam logic [KIND_W-1:0] K_THIS   = 6'd34;
    localparam logic [KIND_W-1:0] K_TRUE   = 6'd35;
    localparam logic [KIND_W-1:0] K_LET    = 6'd36;
    localparam logic [KIND_W-1:0] K_WHILE  = 6'd37;
    localparam logic [KIND_W-1:0] K_ERROR  = 6'd38;
    localparam logic [KIND_W-1:0] K_END    = 6'd39;

    localparam logic [ERR_W-1:0] E_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] E_UNEXPECT = 2'd1;
    localparam logic [ERR_W-1:0] E_UNTERM   = 2'd2;

    typedef enum logic [2:0] {
        M_IDLE, M_NUMBER, M_NUMDOT, M_IDENT, M_STRING, M_COMMENT, M_OPER
    } scan_mode_t;

    // one finished token as handed from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic [ERR_W-1:0]  err;
        logic              last;
    } token_t;

    localparam int TOKEN_W = $bits(token_t);

    // up to three tokens produced by one byte
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } bundle_t;

    function automatic logic char_numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic char_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // single-byte punctuation; valid clear means unexpected character
    function automatic logic [KIND_W:0] punct_kind(input logic [7:0] c);
        logic [KIND_W:0] r;
        r = '0;
        unique case (c)
            "(":     r = {1'b1, K_LPAREN};
            ")":     r = {1'b1, K_RPAREN};
            "{":     r = {1'b1, K_LBRACE};
            "}":     r = {1'b1, K_RBRACE};
            ",":     r = {1'b1, K_COMMA};
            ".":     r = {1'b1, K_DOT};
            "-":     r = {1'b1, K_MINUS};
            "+":     r = {1'b1, K_PLUS};
            ";":     r = {1'b1, K_SEMI};
            "/":     r = {1'b1, K_SLASH};
            "*":     r = {1'b1, K_STAR};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] oper_kind(input logic [7:0] op, input logic two);
        logic [KIND_W-1:0] b;
        b = (op == "!") ? K_BANG : (op == "=") ? K_EQUAL : (op == ">") ? K_GREATER : K_LESS;
        return two ? b + KIND_W'(1) : b;
    endfunction

    // exact keyword match on first six bytes and length
    function automatic logic [KIND_W-1:0] keyword_kind(input logic [47:0] p,
                                                     input logic [2:0] n);
        logic [KIND_W-1:0] r;
        r = K_IDENT;
        unique case (n)
            3'd2: begin
                if (p[15:0] == {"n", "f"}) r = K_FN;
                else if (p[15:0] == {"f", "i"}) r = K_IF;
                else if (p[15:0] == {"r", "o"}) r = K_OR;
            end
            3'd3: begin
                if (p[23:0] == {"d", "n", "a"}) r = K_AND;
                else if (p[23:0] == {"r", "o", "f"}) r = K_FOR;
                else if (p[23:0] == {"l", "i", "n"}) r = K_NIL;
                else if (p[23:0] == {"t", "e", "l"}) r = K_LET;
            end
            3'd4: begin
                if (p[31:0] == {"e", "s", "l", "e"}) r = K_ELSE;
                else if (p[31:0] == {"s", "i", "h", "t"}) r = K_THIS;
                else if (p[31:0] == {"e", "u", "r", "t"}) r = K_TRUE;
            end
            3'd5: begin
                if (p[39:0] == {"s", "s", "a", "l", "c"}) r = K_CLASS;
                else if (p[39:0] == {"e", "s", "l", "a", "f"}) r = K_FALSE;
                else if (p[39:0] == {"t", "n", "i", "r", "p"}) r = K_PRINT;
                else if (p[39:0] == {"r", "e", "p", "u", "s"}) r = K_SUPER;
                else if (p[39:0] == {"e", "l", "i", "h", "w"}) r = K_WHILE;
            end
            3'd6: begin
                if (p == {"n", "r", "u", "t", "e", "r"}) r = K_RETURN;
            end
            default: r = K_IDENT;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/sts_front.sv @@
// ----------------------------------------------------------------------------
// sts_front
// Per-byte scanner: tracks the lexer mode and produces up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sts_front #(
    parameter int OFFSET_BITS     = sts_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS       = sts_pkg::LINE_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = sts_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_char,
    input  wire logic            in_end,
    output sts_pkg::bundle_t     bundle
);
    localparam int KLW = $clog2(KEYWORD_MAX_LEN + 1);
    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LN_MAX  = '1;

    sts_pkg::scan_mode_t     mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]  start_reg, start_next;
    logic [OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic                    frac_reg, frac_next;
    logic [7:0]              op_reg, op_next;
    logic [7:0]              kw_reg [KEYWORD_MAX_LEN];
    logic [KLW-1:0]          klen_reg, klen_next;   // identifier length, capped
    logic                    klong_reg, klong_next; // longer than the prefix store
    logic                    kw_we;
    logic [KLW-1:0]          kw_wa;

    sts_pkg::token_t         tok [3];
    logic [1:0]              cnt;
    logic [LINE_BITS-1:0]    line_out;

    function automatic logic [sts_pkg::OUT_W-1:0] clip(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+sts_pkg::OUT_W-1:0] w;
        w = {{sts_pkg::OUT_W{1'b0}}, v};
        if (w > {{OFFSET_BITS{1'b0}}, {sts_pkg::OUT_W{1'b1}}}) return '1;
        return w[sts_pkg::OUT_W-1:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                                    input logic [OFFSET_BITS-1:0] b);
        return (b > a) ? b - a : '0;
    endfunction

    function automatic logic [sts_pkg::LINE_W-1:0] clipl(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+sts_pkg::LINE_W-1:0] w;
        w = {{sts_pkg::LINE_W{1'b0}}, v};
        if (w > {{LINE_BITS{1'b0}}, {sts_pkg::LINE_W{1'b1}}}) return '1;
        return w[sts_pkg::LINE_W-1:0];
    endfunction

    logic [47:0] kw_flat;
    always_comb begin
        kw_flat = '0;
        for (int i = 0; i < 6; i++) kw_flat[i*8 +: 8] = kw_reg[i];
    end

    always_comb begin
        logic [7:0]             c;
        logic                   fin;
        logic                   redo;
        logic [OFFSET_BITS-1:0] pos, pos1, dot;
        logic [sts_pkg::KIND_W-1:0] ik;
        logic [sts_pkg::KIND_W:0] pk;
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        frac_next  = frac_reg;
        op_next    = op_reg;
        klen_next  = klen_reg;
        klong_next = klong_reg;
        kw_we      = 1'b0;
        kw_wa      = klen_reg;
        cnt        = '0;
        for (int i = 0; i < 3; i++) tok[i] = '0;
        c    = in_char;
        fin  = in_end || (in_char == 8'd0);
        pos  = pos_reg;
        pos1 = (pos_reg < OFS_MAX) ? pos_reg + 1'b1 : pos_reg;
        dot  = (pos_reg > 0) ? pos_reg - 1'b1 : '0;
        redo = 1'b0;
        ik   = (klong_reg || klen_reg > KLW'(6)) ? sts_pkg::K_IDENT
             : sts_pkg::keyword_kind(kw_flat, 3'(klen_reg));
        pk   = '0;

        if (in_valid) begin
            if (fin) begin
                unique case (mode_reg)
                    sts_pkg::M_STRING: begin
                        tok[0] = '{sts_pkg::K_ERROR, clip(start_reg), clip(span(start_reg, pos)),
                                   '0, sts_pkg::E_UNTERM, 1'b0};
                        cnt = 2'd1;
                    end
                    sts_pkg::M_NUMBER, sts_pkg::M_OPER: begin
                        tok[0] = '{(mode_reg == sts_pkg::M_NUMBER) ? sts_pkg::K_NUMBER
                                   : sts_pkg::oper_kind(op_reg, 1'b0), clip(start_reg),
                                   clip(span(start_reg, pos)), '0, sts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                    end
                    sts_pkg::M_IDENT: begin
                        tok[0] = '{ik, clip(start_reg), clip(span(start_reg, pos)), '0,
                                   sts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                    end
                    sts_pkg::M_NUMDOT: begin
                        tok[0] = '{sts_pkg::K_NUMBER, clip(start_reg), clip(span(start_reg, dot)),
                                   '0, sts_pkg::E_NONE, 1'b0};
                        tok[1] = '{sts_pkg::K_DOT, clip(dot), 32'd1, '0, sts_pkg::E_NONE, 1'b0};
                        cnt = 2'd2;
                    end
                    default: cnt = '0;
                endcase
                tok[cnt] = '{sts_pkg::K_END, clip(pos), '0, '0, sts_pkg::E_NONE, 1'b1};
                cnt = cnt + 2'd1;
                mode_next  = sts_pkg::M_IDLE;
                start_next = '0;
                pos_next   = '0;
                line_next  = LINE_BITS'(1);
                frac_next  = 1'b0;
                op_next    = '0;
            end else begin
                unique case (mode_reg)
                    sts_pkg::M_COMMENT: begin
                        if (c == 8'h0a) begin
                            mode_next = sts_pkg::M_IDLE;
                            if (line_reg < LN_MAX) line_next = line_reg + 1'b1;
                        end
                    end
                    sts_pkg::M_STRING: begin
                        if (c == "\"") begin
                            tok[0] = '{sts_pkg::K_STRING, clip(start_reg), clip(span(start_reg, pos1)),
                                       '0, sts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1;
                            mode_next = sts_pkg::M_IDLE;
                        end else if (c == 8'h0a) begin
                            if (line_reg < LN_MAX) line_next = line_reg + 1'b1;
                        end
                    end
                    sts_pkg::M_NUMBER: begin
                        if (sts_pkg::char_numeral(c)) begin
                        end else if (c == "." && !frac_reg) begin
                            mode_next = sts_pkg::M_NUMDOT;
                        end else begin
                            tok[0] = '{sts_pkg::K_NUMBER, clip(start_reg), clip(span(start_reg, pos)),
                                       '0, sts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    sts_pkg::M_NUMDOT: begin
                        if (sts_pkg::char_numeral(c)) begin
                            frac_next = 1'b1;
                            mode_next = sts_pkg::M_NUMBER;
                        end else begin
                            tok[0] = '{sts_pkg::K_NUMBER, clip(start_reg), clip(span(start_reg, dot)),
                                       '0, sts_pkg::E_NONE, 1'b0};
                            tok[1] = '{sts_pkg::K_DOT, clip(dot), 32'd1, '0, sts_pkg::E_NONE, 1'b0};
                            cnt = 2'd2;
                            redo = 1'b1;
                        end
                    end
                    sts_pkg::M_IDENT: begin
                        if (sts_pkg::char_letter(c) || sts_pkg::char_numeral(c)) begin
                            // length follows the offset span, so it stops once the offset saturates
                            if (klen_reg < KLW'(KEYWORD_MAX_LEN)) begin
                                kw_we = 1'b1;
                                kw_wa = klen_reg;
                                if (pos_reg != OFS_MAX) klen_next = klen_reg + 1'b1;
                            end else if (pos_reg != OFS_MAX) begin
                                klong_next = 1'b1;
                            end
                        end else begin
                            tok[0] = '{ik, clip(start_reg), clip(span(start_reg, pos)), '0,
                                       sts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    sts_pkg::M_OPER: begin
                        if (c == "=") begin
                            tok[0] = '{sts_pkg::oper_kind(op_reg, 1'b1), clip(start_reg),
                                       clip(span(start_reg, pos1)), '0, sts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1;
                            mode_next = sts_pkg::M_IDLE;
                        end else begin
                            tok[0] = '{sts_pkg::oper_kind(op_reg, 1'b0), clip(start_reg),
                                       clip(span(start_reg, pos)), '0, sts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    default: redo = 1'b1;
                endcase

                if (redo) begin
                    mode_next = sts_pkg::M_IDLE;
                    pk = sts_pkg::punct_kind(c);
                    if (c == " " || c == 8'h09 || c == 8'h0d) begin
                    end else if (c == 8'h0a) begin
                        if (line_reg < LN_MAX) line_next = line_reg + 1'b1;
                    end else if (c == "#") begin
                        mode_next = sts_pkg::M_COMMENT;
                    end else if (sts_pkg::char_numeral(c)) begin
                        mode_next = sts_pkg::M_NUMBER;
                        start_next = pos;
                        frac_next = 1'b0;
                    end else if (sts_pkg::char_letter(c)) begin
                        mode_next = sts_pkg::M_IDENT;
                        start_next = pos;
                        kw_we = 1'b1;
                        kw_wa = '0;
                        klen_next = (pos_reg != OFS_MAX) ? KLW'(1) : '0;
                        klong_next = 1'b0;
                    end else if (c == "\"") begin
                        mode_next = sts_pkg::M_STRING;
                        start_next = pos;
                    end else if (c == "!" || c == "=" || c == "<" || c == ">") begin
                        mode_next = sts_pkg::M_OPER;
                        start_next = pos;
                        op_next = c;
                    end else begin
                        tok[cnt] = pk[sts_pkg::KIND_W]
                            ? '{pk[sts_pkg::KIND_W-1:0], clip(pos), 32'd1, '0, sts_pkg::E_NONE, 1'b0}
                            : '{sts_pkg::K_ERROR, clip(pos), 32'd1, '0, sts_pkg::E_UNEXPECT, 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
                pos_next = pos1;
                if (cnt != '0) tok[cnt - 2'd1].last = 1'b1;
            end
        end
    end

    // tokens carry the count held before this byte; a newline that ends a token
    // is counted only after that token has gone out
    assign line_out = line_reg;

    always_comb begin
        bundle.count = cnt;
        bundle.t0 = tok[0];
        bundle.t1 = tok[1];
        bundle.t2 = tok[2];
        bundle.t0.line = clipl(line_out);
        bundle.t1.line = clipl(line_out);
        bundle.t2.line = clipl(line_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sts_pkg::M_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            frac_reg  <= 1'b0;
            op_reg    <= '0;
            klen_reg  <= '0;
            klong_reg <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            frac_reg  <= frac_next;
            op_reg    <= op_next;
            klen_reg  <= klen_next;
            klong_reg <= klong_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && kw_we) kw_reg[kw_wa] <= in_char;
    end

    `ASSERT_CLK(a_line_nonzero, aclk, aresetn, line_reg != '0, "line count dropped to zero")
    `ASSERT_CLK(a_end_resets, aclk, aresetn,
        (in_valid && in_end) |=> (pos_reg == '0 && mode_reg == sts_pkg::M_IDLE),
        "end of input did not return scanner to reset state")
    `ASSERT_CLK(a_count_nonzero_last, aclk, aresetn,
        (in_valid && in_end) |-> (bundle.count != 2'd0),
        "end of input produced no end token")

endmodule
`default_nettype wire

@@ src/sts_queue.sv @@
// ----------------------------------------------------------------------------
// sts_queue
// Token FIFO between the scanner and the output; space for three per byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sts_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sts_pkg::bundle_t bundle,
    output logic               space_ok,
    output logic               out_valid,
    output sts_pkg::token_t    out_tok,
    input  wire logic          out_ready
);
    localparam int DEPTH = 8;
    localparam int AW    = 3;

    sts_pkg::token_t  mem [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             pop;

    assign out_valid = (cnt_reg != '0);
    assign out_tok   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    // three free slots needed regardless of this cycle's pop
    assign space_ok  = (cnt_reg <= (AW+1)'(DEPTH - 3));

    always_comb begin
        cnt_next = cnt_reg + (AW+1)'(bundle.count) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (bundle.count > 2'd0) mem[wr_reg] <= bundle.t0;
        if (bundle.count > 2'd1) mem[wr_reg + AW'(1)] <= bundle.t1;
        if (bundle.count > 2'd2) mem[wr_reg + AW'(2)] <= bundle.t2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + AW'(bundle.count);
            rd_reg  <= rd_reg + AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_CLK(a_no_overflow, aclk, aresetn, cnt_reg <= (AW+1)'(DEPTH), "token queue overflow")
    `ASSERT_CLK(a_count_track, aclk, aresetn,
        ((wr_reg - rd_reg) == cnt_reg[AW-1:0]), "queue pointers disagree with count")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> cnt_reg == '0, "queue not empty after reset")

endmodule
`default_nettype wire

@@ src/script_token_scanner_top.sv @@
// ----------------------------------------------------------------------------
// script_token_scanner_top
// Streaming lexical scanner: one source byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                      | tlast
//  s_      | in  | char_byte[7:0]                                          | end_of_input
//  m_      | out | kind[5:0] start[37:6] len[69:38] line[93:70] err[95:94] | last_of_run
//
//  One byte is taken per cycle while s_tready is high; the scanner resolves it in that
//  same cycle. Tokens wait in an eight-entry queue; s_tready drops while fewer than
//  three slots are free, so the token drain rate (one per cycle, held by m_tready) sets
//  the pace. Reset is synchronous, active low; queue and scanner state clear at once.
// ----------------------------------------------------------------------------
`default_nettype none
module script_token_scanner_top #(
    parameter int OFFSET_BITS     = sts_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS       = sts_pkg::LINE_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = sts_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // token_kind, start_offset, token_length,
                                        // line_number, error_code
    output logic             m_tlast    // last_of_run
);
    sts_pkg::bundle_t bundle;
    sts_pkg::token_t  tok;
    logic             space_ok;

    assign s_tready = space_ok;

    sts_front #(
        .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid && space_ok),
        .in_char(s_tdata), .in_end(s_tlast), .bundle(bundle)
    );

    sts_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .bundle(bundle), .space_ok(space_ok),
        .out_valid(m_tvalid), .out_tok(tok), .out_ready(m_tready)
    );

    assign m_tdata = {tok.err, tok.line, tok.len, tok.start, tok.kind};
    assign m_tlast = tok.last;

endmodule
`default_nettype wire
